// ===== rtl/bbh_pkg.sv =====
// Shared types, constants and fixed-point helpers for the orbit histogram block.
// Used by buddhabrot_orbit_histogram; depends on nothing else.
`default_nettype none

package bbh_pkg;

  // Fixed-point format of orbit values: signed, FRAC_BITS fraction bits.
  localparam int FRAC_BITS  = 28;
  localparam int VAL_W      = FRAC_BITS + 4;
  localparam int PT_W       = VAL_W - 1;
  localparam int ITER_W     = 16;
  localparam int COL_BITS   = 8;
  localparam int ROW_BITS   = 8;
  localparam int CELL_BITS  = COL_BITS + ROW_BITS;
  localparam int CELLS      = 1 << CELL_BITS;
  localparam int COUNT_BITS = 32;
  localparam int SCALE_W    = 32;
  localparam int PROD_W     = 2 * VAL_W;
  // Scale is Q16.16, so a pixel coordinate drops FRAC_BITS + 16 bits.
  localparam int PIX_SHIFT  = FRAC_BITS + 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [VAL_W-1:0] QMAX   = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W:0]   QMAX_W = {2'b00, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W:0]   QMIN_W = -QMAX_W;
  localparam logic [VAL_W:0]          ESCAPE_SQ = (VAL_W+1)'(4) << FRAC_BITS;
  localparam logic [COUNT_BITS-1:0]   COUNT_MAX = '1;

  localparam logic [ITER_W-1:0]     RST_N_ITER  = ITER_W'(256);
  localparam logic [VAL_W-1:0]      RST_EDGE    = VAL_W'(-(64'sd2) <<< FRAC_BITS);
  localparam logic [SCALE_W-1:0]    RST_SCALE   = SCALE_W'(64) << 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_N_ITER  = 3'd0,
    CFG_RE_MIN  = 3'd1,
    CFG_IM_MIN  = 3'd2,
    CFG_SCALE_X = 3'd3,
    CFG_SCALE_Y = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_READ   = 1'b1
  } action_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_PRIME,
    ST_MXY,
    ST_UX,
    ST_UY,
    ST_MYY,
    ST_WYY,
    ST_CHK,
    ST_MROW,
    ST_PIX,
    ST_INC,
    ST_DONE
  } state_t;

  // Sum of two values in range, clamped to +-QMAX.
  function automatic logic signed [VAL_W-1:0] sat_add(input logic signed [VAL_W-1:0] a,
                                                     input logic signed [VAL_W-1:0] b);
    logic signed [VAL_W:0] s;
    s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    if (s > QMAX_W) begin
      return QMAX;
    end else if (s < QMIN_W) begin
      return -QMAX;
    end
    return s[VAL_W-1:0];
  endfunction

  // Magnitude product back to fixed point: truncate, saturate, apply sign.
  function automatic logic signed [VAL_W-1:0] to_fixed(input logic [PROD_W-1:0] prod,
                                                      input logic neg);
    logic [VAL_W-1:0] mag;
    if (prod[PROD_W-1:VAL_W+FRAC_BITS-1] != '0) begin
      mag = QMAX;
    end else begin
      mag = prod[VAL_W+FRAC_BITS-1:FRAC_BITS];
    end
    return neg ? -mag : mag;
  endfunction

  function automatic logic [VAL_W-1:0] magnitude(input logic signed [VAL_W-1:0] v);
    return v[VAL_W-1] ? -v : v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/buddhabrot_orbit_histogram.sv =====
// Escape-orbit histogram: escape test, orbit replay and a 64K-cell hit memory.
// Depends on bbh_pkg for types, constants and the fixed-point helpers.
//
//   channel  | signals                                    | direction
//   ---------+--------------------------------------------+----------
//   item     | item_valid, item_stall, action, point_*,   | in
//            | cell_col, cell_row                         |
//   result   | result_valid, result_stall, escaped,       | out
//            | cells_hit, cell_value                      |
//   cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data  | in
//
// One shared 32x32 multiplier does every product. An escape step issues three products,
// makes two updates and one compare; a replay step also maps the point to a cell and
// increments that cell when the point lands in the window. After reset the memory is
// cleared before the first word is taken. item_stall is high whenever an item is in
// work; a held result does not stop the next item from being accepted, but a finished
// item waits in ST_DONE until the held result is taken.
`default_nettype none

module buddhabrot_orbit_histogram
  import bbh_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         item_valid,
  output      logic                         item_stall,
  input  wire logic                         action,
  input  wire logic signed [PT_W-1:0]       point_re,
  input  wire logic signed [PT_W-1:0]       point_im,
  input  wire logic        [COL_BITS-1:0]   cell_col,
  input  wire logic        [ROW_BITS-1:0]   cell_row,
  output      logic                         result_valid,
  input  wire logic                         result_stall,
  output      logic                         escaped,
  output      logic        [ITER_W-1:0]     cells_hit,
  output      logic        [COUNT_BITS-1:0] cell_value,
  input  wire logic                         cfg_valid,
  output      logic                         cfg_ready,
  input  wire logic        [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic        [CFG_DATA_W-1:0] cfg_data
);

  state_t state, state_next;

  // Configuration.
  logic        [ITER_W-1:0]  n_iter;
  logic signed [VAL_W-1:0]   win_re;
  logic signed [VAL_W-1:0]   win_im;
  logic        [SCALE_W-1:0] scale_x;
  logic        [SCALE_W-1:0] scale_y;

  // Orbit datapath.
  logic signed [VAL_W-1:0] cr, ci, x, y, xx, yy, xy;
  logic        [PROD_W-1:0] prod;
  logic                     prod_neg;
  logic        [ITER_W-1:0] iter;
  logic                     priming;
  logic                     replay;
  logic                     out_now_r;
  logic        [VAL_W-1:0]  d_re, d_im;
  logic                     d_re_ok, d_im_ok;
  logic        [COL_BITS-1:0]  col;
  logic                        col_ok;
  logic        [CELL_BITS-1:0] cell_addr;
  logic        [CELL_BITS-1:0] clr_cnt;

  // Word being built for the result register.
  logic                  res_escaped;
  logic [ITER_W-1:0]     res_hits;
  logic [COUNT_BITS-1:0] res_cell;

  // Histogram memory.
  logic [COUNT_BITS-1:0] hist [CELLS];
  logic [COUNT_BITS-1:0] mem_q;
  logic [CELL_BITS-1:0]  mem_raddr;
  logic [CELL_BITS-1:0]  mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic                  mem_we;

  // Shared multiplier controls.
  logic               mul_en;
  logic [VAL_W-1:0]   mul_a, mul_b;
  logic               mul_neg;

  logic                    item_acc;
  logic                    out_free;
  logic [VAL_W:0]          mag_sum;
  logic                    out_now;
  logic [ITER_W-1:0]       iter_inc;
  logic                    iter_last;
  logic                    step_last;
  logic                    row_ok;
  logic [ROW_BITS-1:0]     row;
  logic signed [VAL_W:0]   d_re_full, d_im_full;

  assign item_acc  = item_valid && !item_stall;
  assign out_free  = !result_valid || !result_stall;
  assign cfg_ready = 1'b1;

  // xx and yy are non-negative, so their sum is formed one bit wider and needs no saturation.
  assign mag_sum   = {1'b0, xx} + {1'b0, yy};
  assign out_now   = mag_sum >= ESCAPE_SQ;
  assign iter_inc  = iter + ITER_W'(1);
  assign iter_last = iter_inc == n_iter;
  assign step_last = out_now_r || iter_last;

  assign row    = prod[PIX_SHIFT+ROW_BITS-1:PIX_SHIFT];
  assign row_ok = d_im_ok && (prod[PROD_W-1:PIX_SHIFT+ROW_BITS] == '0);

  assign d_re_full = {x[VAL_W-1], x} - {win_re[VAL_W-1], win_re};
  assign d_im_full = {y[VAL_W-1], y} - {win_im[VAL_W-1], win_im};

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == '1) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (item_acc) begin
          if (action_t'(action) == ACT_READ) begin
            state_next = ST_READ;
          end else if (n_iter == '0) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_PRIME;
          end
        end
      end
      ST_READ:  state_next = ST_DONE;
      ST_PRIME: state_next = ST_MYY;
      ST_MXY:   state_next = ST_UX;
      ST_UX:    state_next = ST_UY;
      ST_UY:    state_next = ST_MYY;
      ST_MYY:   state_next = ST_WYY;
      ST_WYY:   state_next = priming ? ST_MXY : ST_CHK;
      ST_CHK: begin
        if (replay) begin
          state_next = ST_MROW;
        end else if (out_now) begin
          state_next = ST_MXY;
        end else if (iter_last) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_MXY;
        end
      end
      ST_MROW:  state_next = ST_PIX;
      ST_PIX: begin
        if (col_ok && row_ok) begin
          state_next = ST_INC;
        end else begin
          state_next = step_last ? ST_DONE : ST_MXY;
        end
      end
      ST_INC:   state_next = step_last ? ST_DONE : ST_MXY;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control outputs: multiplier operands, memory port, handshake.
  always_comb begin
    item_stall = 1'b1;
    mul_en     = 1'b0;
    mul_a      = magnitude(x);
    mul_b      = magnitude(x);
    mul_neg    = 1'b0;
    mem_raddr  = {cell_row, cell_col};
    mem_we     = 1'b0;
    mem_waddr  = cell_addr;
    mem_wdata  = (mem_q == COUNT_MAX) ? mem_q : mem_q + COUNT_BITS'(1);
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
      end
      ST_IDLE:  item_stall = 1'b0;
      ST_PRIME, ST_UY: begin
        mul_en = 1'b1;
      end
      ST_MYY: begin
        mul_en = 1'b1;
        mul_a  = magnitude(y);
        mul_b  = magnitude(y);
      end
      ST_MXY: begin
        mul_en  = 1'b1;
        mul_b   = magnitude(y);
        mul_neg = x[VAL_W-1] ^ y[VAL_W-1];
      end
      ST_CHK: begin
        mul_en = replay;
        mul_a  = d_re;
        mul_b  = scale_x;
      end
      ST_MROW: begin
        mul_en = 1'b1;
        mul_a  = d_im;
        mul_b  = scale_y;
      end
      ST_PIX:   mem_raddr = {row, col};
      ST_INC:   mem_we = 1'b1;
      ST_READ, ST_UX, ST_WYY, ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // State, configuration and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_cnt      <= '0;
      result_valid <= 1'b0;
      n_iter       <= RST_N_ITER;
      win_re       <= RST_EDGE;
      win_im       <= RST_EDGE;
      scale_x      <= RST_SCALE;
      scale_y      <= RST_SCALE;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + CELL_BITS'(1);

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_N_ITER:  n_iter  <= cfg_data[ITER_W-1:0];
          CFG_RE_MIN:  win_re  <= cfg_data;
          CFG_IM_MIN:  win_im  <= cfg_data;
          CFG_SCALE_X: scale_x <= cfg_data;
          CFG_SCALE_Y: scale_y <= cfg_data;
          default: begin
          end
        endcase
      end

      if (state == ST_DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      escaped    <= res_escaped;
      cells_hit  <= res_hits;
      cell_value <= res_cell;
    end
  end

  // Orbit datapath.
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod     <= mul_a * mul_b;
      prod_neg <= mul_neg;
    end
    unique case (state)
      ST_IDLE: begin
        res_escaped <= 1'b0;
        res_hits    <= '0;
        res_cell    <= '0;
        cr          <= VAL_W'(point_re);
        ci          <= VAL_W'(point_im);
        x           <= VAL_W'(point_re);
        y           <= VAL_W'(point_im);
        iter        <= '0;
        priming     <= 1'b1;
        replay      <= 1'b0;
      end
      ST_READ:  res_cell <= mem_q;
      ST_UX: begin
        xy <= to_fixed(prod, prod_neg);
        x  <= sat_add(sat_add(xx, -yy), cr);
      end
      ST_UY:    y  <= sat_add(sat_add(xy, xy), ci);
      ST_MYY:   xx <= to_fixed(prod, 1'b0);
      ST_WYY: begin
        yy      <= to_fixed(prod, 1'b0);
        priming <= 1'b0;
        d_re    <= d_re_full[VAL_W-1:0];
        d_re_ok <= !d_re_full[VAL_W];
        d_im    <= d_im_full[VAL_W-1:0];
        d_im_ok <= !d_im_full[VAL_W];
      end
      ST_CHK: begin
        out_now_r <= out_now;
        if (!replay) begin
          if (out_now) begin
            // Escaped: replay the orbit from zero.
            res_escaped <= 1'b1;
            replay      <= 1'b1;
            iter        <= '0;
            x           <= '0;
            y           <= '0;
            xx          <= '0;
            yy          <= '0;
          end else begin
            iter <= iter_inc;
          end
        end
      end
      ST_MROW: begin
        col    <= prod[PIX_SHIFT+COL_BITS-1:PIX_SHIFT];
        col_ok <= d_re_ok && (prod[PROD_W-1:PIX_SHIFT+COL_BITS] == '0);
      end
      ST_PIX: begin
        cell_addr <= {row, col};
        if (!(col_ok && row_ok)) iter <= iter_inc;
      end
      ST_INC: begin
        res_hits <= res_hits + ITER_W'(1);
        iter     <= iter_inc;
      end
      ST_CLEAR, ST_PRIME, ST_MXY, ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Histogram memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) hist[mem_waddr] <= mem_wdata;
    mem_q <= hist[mem_raddr];
  end

endmodule

`default_nettype wire
